// ===== rtl/grasp_event_debouncer_macros.svh =====
// Assertion macros shared by the grasp event debouncer checker.
`ifndef GRASP_EVENT_DEBOUNCER_MACROS_SVH
`define GRASP_EVENT_DEBOUNCER_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define GED_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define GED_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/ged_pkg.sv =====
// Package with the command codes, register indexes, event kinds and sequencer states of the grasp event debouncer.
package ged_pkg;
  localparam logic [2:0] CMD_BEGIN_A = 3'd0;
  localparam logic [2:0] CMD_BEGIN_B = 3'd1;
  localparam logic [2:0] CMD_END_A   = 3'd2;
  localparam logic [2:0] CMD_END_B   = 3'd3;
  localparam logic [2:0] CMD_TRIGGER = 3'd4;
  localparam logic [2:0] CMD_TICK    = 3'd5;

  localparam logic [1:0] REG_ENABLE    = 2'd0;
  localparam logic [1:0] REG_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_WINDOW    = 2'd2;

  localparam logic EV_BEGIN = 1'b0;
  localparam logic EV_END   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DECIDE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SCAN_OUT,
    ST_FLUSH,
    ST_OUT
  } ged_state_t;
endpackage

// ===== rtl/ged_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module ged_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== rtl/grasp_event_debouncer.sv =====
// Top level of the grasp event debouncer: sequencer, flag vectors and pending-time memory.
//
//  channel | direction | handshake       | payload
//  in_     | input     | in_valid/stall  | cmd, object_id, now, trigger_level
//  out_    | output    | out_valid/stall | event_kind, event_object, event_time, last
//  cfg_    | input     | valid/ready     | cfg_index, cfg_data
//
// An overlap command passes through the read, decide and output states after its transfer,
// and no new item is taken until the sequencer is idle and the output register is empty.
// A tick or a pause walks every object through the single pending-time read port and
// the one age subtractor, in the scan read, check and output states per object and then
// a flush state; a stalled output holds the walk in the output or flush state.
// Reset clears every flag vector at once; the pending-time memory needs no clearing.
module grasp_event_debouncer #(
  parameter int NUM_OBJECTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [5:0]  in_object_id,
  input  logic [31:0] in_now,
  input  logic [15:0] in_trigger_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_event_kind,
  output logic [5:0]  out_event_object,
  output logic [31:0] out_event_time,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);
  import ged_pkg::*;

  localparam int AW = $clog2(NUM_OBJECTS);

  ged_state_t state_r, state_nxt;

  // Configuration registers.
  logic        enable_r;
  logic [15:0] thresh_r;
  logic [19:0] window_r;

  // Per-object flags; valid bits live in flip-flops so reset clears them at once.
  logic [NUM_OBJECTS-1:0] in_a_r, in_b_r, grasped_r, pend_r;
  logic                   paused_r;

  // Captured input item.
  logic [2:0]    cmd_r;
  logic [AW-1:0] obj_r;
  logic [31:0]   now_r;

  // Scan index over all object entries.
  logic [AW-1:0] idx_r;

  // The new pending time of an overlap end is written once the decide step is done,
  // after the old pending time has been copied into the output register.
  logic        wr_pend_r;

  // A scan result is held back until the next hit or the end of the walk, so that
  // the last flag is known when it leaves.
  logic        hv_r;
  logic [5:0]  hobj_r;
  logic [31:0] htime_r;

  // Output register.
  logic        ov_r, okind_r, olast_r;
  logic [5:0]  oobj_r;
  logic [31:0] otime_r;
  logic        ov_set;

  // Memory port.
  logic          ram_we;
  logic [AW-1:0] ram_wa, ram_ra;
  logic [31:0]   ram_rd;

  ged_ram #(.WIDTH(32), .DEPTH(NUM_OBJECTS)) u_pend_time (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (now_r),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  // The shared age unit: one subtract and compare against the window.
  logic [31:0] age;
  logic        age_lt, age_gt;
  assign age    = now_r - ram_rd;
  assign age_lt = age < {12'd0, window_r};
  assign age_gt = age > {12'd0, window_r};

  logic [AW-1:0] sidx;
  assign sidx = idx_r;

  logic in_acc, out_acc, out_free;
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = ov_r && !out_stall;
  assign out_free = !ov_r || !out_stall;

  assign in_stall  = (state_r != ST_IDLE) || ov_r;
  assign cfg_ready = (state_r == ST_IDLE) && !in_valid;

  // Overlap command decode on the captured item.
  logic op_b, op_end, mine, other;
  assign op_b   = cmd_r[0];
  assign op_end = cmd_r[1];
  assign mine   = op_b ? in_b_r[obj_r] : in_a_r[obj_r];
  assign other  = op_b ? in_a_r[obj_r] : in_b_r[obj_r];

  // A begin inside the window swallows the pending end; otherwise the begin is
  // reported. An end reports only an older end that is still pending.
  logic dec_merge, dec_begin, dec_end;
  assign dec_merge = pend_r[obj_r] && age_lt;
  assign dec_begin = !op_end && !mine && other && !grasped_r[obj_r] && !dec_merge;
  assign dec_end   = op_end && mine && grasped_r[obj_r] && pend_r[obj_r];

  // A pause scan ends every grasped object now; a tick scan publishes old pending ends.
  logic        scan_trig, scan_hit;
  logic [31:0] scan_time;
  assign scan_trig = (cmd_r == CMD_TRIGGER);
  assign scan_hit  = scan_trig ? grasped_r[sidx] : (pend_r[sidx] && age_gt);
  assign scan_time = scan_trig ? now_r : ram_rd;

  logic in_obj_ok;
  assign in_obj_ok = ({26'd0, in_object_id} < 32'(NUM_OBJECTS));

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_cmd <= CMD_END_B) begin
            if (!paused_r && enable_r && in_obj_ok) state_nxt = ST_READ;
          end else if (in_cmd == CMD_TRIGGER) begin
            if (in_trigger_level < thresh_r && !paused_r) state_nxt = ST_SCAN_RD;
          end else if (in_cmd == CMD_TICK) begin
            state_nxt = ST_SCAN_RD;
          end
        end
      end
      ST_READ:     state_nxt = ST_DECIDE;
      ST_DECIDE:   if (out_free) state_nxt = ST_OUT;
      ST_OUT:      if (out_free) state_nxt = ST_IDLE;
      ST_SCAN_RD:  state_nxt = ST_SCAN_CHK;
      ST_SCAN_CHK: state_nxt = ST_SCAN_OUT;
      ST_SCAN_OUT: begin
        if (out_free) begin
          state_nxt = (idx_r == AW'(NUM_OBJECTS - 1)) ? ST_FLUSH : ST_SCAN_RD;
        end
      end
      ST_FLUSH:    if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Output load: a new result enters the output register only when it is free.
  always_comb begin
    ov_set = 1'b0;
    if (out_free) begin
      unique case (state_r)
        ST_DECIDE:   ov_set = dec_begin || dec_end;
        ST_SCAN_OUT: ov_set = scan_hit && hv_r;
        ST_FLUSH:    ov_set = hv_r;
        default:     ov_set = 1'b0;
      endcase
    end
  end

  // Memory addressing.
  always_comb begin
    ram_ra = (state_r == ST_IDLE) ? AW'(in_object_id) : obj_r;
    if (state_r == ST_SCAN_RD || state_r == ST_SCAN_CHK || state_r == ST_SCAN_OUT) begin
      ram_ra = sidx;
    end
    ram_we = (state_r == ST_OUT) && out_free && wr_pend_r;
    ram_wa = obj_r;
  end

  // Datapath and flag updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      enable_r  <= 1'b1;
      thresh_r  <= 16'd19661;
      window_r  <= 20'd420;
      in_a_r    <= '0;
      in_b_r    <= '0;
      grasped_r <= '0;
      pend_r    <= '0;
      paused_r  <= 1'b0;
      ov_r      <= 1'b0;
      hv_r      <= 1'b0;
      wr_pend_r <= 1'b0;
      idx_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (ov_set) ov_r <= 1'b1;
      else if (out_acc) ov_r <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_ENABLE:    enable_r <= cfg_data[0];
          REG_THRESHOLD: thresh_r <= cfg_data[15:0];
          REG_WINDOW:    window_r <= cfg_data;
          default: ;
        endcase
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            cmd_r <= in_cmd;
            obj_r <= AW'(in_object_id);
            now_r <= in_now;
            idx_r <= '0;
            wr_pend_r <= 1'b0;
            if (in_cmd == CMD_TRIGGER) begin
              if (in_trigger_level >= thresh_r) paused_r <= 1'b0;
              else if (!paused_r) paused_r <= 1'b1;
            end
          end
        end
        ST_READ: ;
        ST_DECIDE: begin
          if (out_free) begin
            if (!op_end) begin
              if (!mine) begin
                if (op_b) in_b_r[obj_r] <= 1'b1;
                else      in_a_r[obj_r] <= 1'b1;
                if (other && !grasped_r[obj_r]) begin
                  grasped_r[obj_r] <= 1'b1;
                  if (dec_merge) pend_r[obj_r] <= 1'b0;
                end
              end
            end else if (mine) begin
              if (op_b) in_b_r[obj_r] <= 1'b0;
              else      in_a_r[obj_r] <= 1'b0;
              if (grasped_r[obj_r]) begin
                grasped_r[obj_r] <= 1'b0;
                pend_r[obj_r]    <= 1'b1;
                wr_pend_r        <= 1'b1;
              end
            end
            if (dec_begin) begin
              okind_r <= EV_BEGIN;
              oobj_r  <= 6'(obj_r);
              otime_r <= now_r;
              olast_r <= 1'b1;
            end
            if (dec_end) begin
              okind_r <= EV_END;
              oobj_r  <= 6'(obj_r);
              otime_r <= ram_rd;
              olast_r <= 1'b1;
            end
          end
        end
        ST_OUT: ;
        ST_SCAN_RD: ;
        ST_SCAN_CHK: ;
        ST_SCAN_OUT: begin
          if (out_free) begin
            if (scan_trig) begin
              grasped_r[sidx] <= 1'b0;
              in_a_r[sidx]    <= 1'b0;
              in_b_r[sidx]    <= 1'b0;
            end else if (scan_hit) begin
              pend_r[sidx] <= 1'b0;
            end
            if (scan_hit) begin
              // A newer hit means the held result is not the last one.
              if (hv_r) begin
                okind_r <= EV_END;
                oobj_r  <= hobj_r;
                otime_r <= htime_r;
                olast_r <= 1'b0;
              end
              hv_r    <= 1'b1;
              hobj_r  <= 6'(sidx);
              htime_r <= scan_time;
            end
            idx_r <= idx_r + AW'(1);
          end
        end
        ST_FLUSH: begin
          if (out_free && hv_r) begin
            okind_r <= EV_END;
            oobj_r  <= hobj_r;
            otime_r <= htime_r;
            olast_r <= 1'b1;
            hv_r    <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid        = ov_r;
  assign out_event_kind   = okind_r;
  assign out_event_object = oobj_r;
  assign out_event_time   = otime_r;
  assign out_last         = olast_r;
endmodule

// ===== rtl/ged_checker.sv =====
// Port-level checker for the grasp event debouncer, bound to the top level.
module ged_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_last,
  input logic       cfg_valid,
  input logic       cfg_ready,
  input logic [2:0] in_cmd
);
  `include "grasp_event_debouncer_macros.svh"
  import ged_pkg::*;

  `GED_ASSERT_IMP(a_cfg_not_busy, clk, rst_n, cfg_valid && cfg_ready, !in_valid)
  `GED_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `GED_ASSERT_NEXT(a_last_hold, clk, rst_n, out_valid && out_stall, $stable(out_last))
  `GED_ASSERT_NEXT(a_tick_busy, clk, rst_n, in_valid && !in_stall && in_cmd == CMD_TICK, in_stall)
  `GED_ASSERT_IMP(a_no_out_when_free, clk, rst_n, !in_stall, !out_valid)
endmodule

bind grasp_event_debouncer ged_checker u_ged_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_last  (out_last),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .in_cmd    (in_cmd)
);
